// ----- design/i128div_pkg.sv -----
// Shared types and constants for the 128-bit divider with rounding modes.
`timescale 1ns / 1ps
package i128div_pkg;

   localparam int WORD_W = 128;
   localparam int HALF_W = 64;
   localparam int STEP_W = $clog2(WORD_W);
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic OP_DIV = 1'b0;
   localparam logic OP_REM = 1'b1;

   localparam logic [1:0] ROUND_TRUNC = 2'd0;
   localparam logic [1:0] ROUND_HALF  = 2'd1;
   localparam logic [1:0] ROUND_AWAY  = 2'd2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_DIV_ZERO = 1'b1;

   typedef struct packed {
      logic              op;
      logic [1:0]        mode;
      logic              negative;
      logic              div_zero;
      logic [WORD_W-1:0] num;
      logic [WORD_W-1:0] den;
   } entry_type;

   typedef enum logic [2:0] {
      CORE_IDLE,
      CORE_DIVIDE,
      CORE_ROUND,
      CORE_SIGN,
      CORE_DONE
   } core_state_type;

endpackage

// ----- design/int128_divider_rounding_modes.sv -----
// Top level of the 128-bit divider with rounding modes.
// Path of a request: registered in the front end, written to the queue, loaded by the core,
// then 128 shift-subtract steps, a rounding step and a sign fix-up step.
// The single restoring divide core works on one request at a time; others wait in the queue.
// Divide by zero skips the loop.
// Reset: synchronous, active high; empties the queue and returns the core to idle.
`timescale 1ns / 1ps
module int128_divider_rounding_modes
   import i128div_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic              req_is_signed,
   input  logic [1:0]        req_rounding_mode,
   input  logic [HALF_W-1:0] req_dividend_lo,
   input  logic [HALF_W-1:0] req_dividend_hi,
   input  logic [HALF_W-1:0] req_divisor_lo,
   input  logic [HALF_W-1:0] req_divisor_hi,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HALF_W-1:0] rsp_result_lo,
   output logic [HALF_W-1:0] rsp_result_hi,
   output logic              rsp_status
);

   logic      push, pop, queue_full, queue_empty;
   entry_type push_entry, pop_entry;

   i128div_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_is_signed     (req_is_signed),
      .req_rounding_mode (req_rounding_mode),
      .req_dividend_lo   (req_dividend_lo),
      .req_dividend_hi   (req_dividend_hi),
      .req_divisor_lo    (req_divisor_lo),
      .req_divisor_hi    (req_divisor_hi),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   i128div_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   i128div_core u_core (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .queue_entry   (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result_lo (rsp_result_lo),
      .rsp_result_hi (rsp_result_hi),
      .rsp_status    (rsp_status)
   );

endmodule

// ----- design/i128div_front.sv -----
// Request front end: registers a request, takes magnitudes for a signed divide and flags a zero divisor.
`timescale 1ns / 1ps
module i128div_front
   import i128div_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic                req_is_signed,
   input  logic [1:0]          req_rounding_mode,
   input  logic [HALF_W-1:0]   req_dividend_lo,
   input  logic [HALF_W-1:0]   req_dividend_hi,
   input  logic [HALF_W-1:0]   req_divisor_lo,
   input  logic [HALF_W-1:0]   req_divisor_hi,
   input  logic                queue_full,
   output logic                push,
   output entry_type           push_entry
);

   logic              valid_ff, valid_in;
   entry_type         entry_ff, entry_in;
   logic              accept;
   logic [WORD_W-1:0] num_raw, den_raw;
   logic              num_neg, den_neg, signed_div;

   assign accept    = req_valid & ~req_stall;
   assign push      = valid_ff & ~queue_full;
   assign req_stall = valid_ff & queue_full;
   assign valid_in  = accept | (valid_ff & ~push);

   always_comb begin
      num_raw    = {req_dividend_hi, req_dividend_lo};
      den_raw    = {req_divisor_hi, req_divisor_lo};
      signed_div = (req_type == OP_DIV) & req_is_signed;
      num_neg    = signed_div & num_raw[WORD_W-1];
      den_neg    = signed_div & den_raw[WORD_W-1];
      entry_in.op       = req_type;
      entry_in.mode     = req_rounding_mode;
      entry_in.negative = num_neg ^ den_neg;
      entry_in.div_zero = (den_raw == '0);
      entry_in.num      = num_neg ? (~num_raw + WORD_W'(1)) : num_raw;
      entry_in.den      = den_neg ? (~den_raw + WORD_W'(1)) : den_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_entry = entry_ff;

endmodule

// ----- design/i128div_fifo.sv -----
// Short request queue between the front end and the divide core.
`timescale 1ns / 1ps
module i128div_fifo
   import i128div_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop & ~push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push & full |-> pop)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");
`endif

endmodule

// ----- design/i128div_core.sv -----
// Divide core: restoring shift-subtract over 128 steps, then rounding and sign fix-up.
`timescale 1ns / 1ps
module i128div_core
   import i128div_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  entry_type           queue_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HALF_W-1:0]   rsp_result_lo,
   output logic [HALF_W-1:0]   rsp_result_hi,
   output logic                rsp_status
);

   core_state_type    state_ff, state_in;
   logic [WORD_W-1:0] num_ff, rem_ff, den_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              op_ff, negative_ff, status_ff;
   logic [1:0]        mode_ff;

   logic [WORD_W:0]   shifted;
   logic [WORD_W+1:0] diff;
   logic              ge;
   logic [WORD_W:0]   dbl;
   logic              half_ge, inc;
   logic [WORD_W-1:0] quo_round;

   always_comb begin
      shifted = {rem_ff, num_ff[WORD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ge      = ~diff[WORD_W+1];
      dbl     = {rem_ff, 1'b0};
      half_ge = (dbl >= {1'b0, den_ff});
      case (mode_ff)
         ROUND_HALF: inc = half_ge;
         ROUND_AWAY: inc = (rem_ff != '0);
         default:    inc = 1'b0;
      endcase
      quo_round = num_ff + WORD_W'(inc);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (!queue_empty) begin
               state_in = queue_entry.div_zero ? CORE_DONE : CORE_DIVIDE;
            end
         end
         CORE_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = CORE_ROUND;
            end
         end
         CORE_ROUND: state_in = CORE_SIGN;
         CORE_SIGN:  state_in = CORE_DONE;
         CORE_DONE: begin
            if (!rsp_stall) begin
               state_in = CORE_IDLE;
            end
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         CORE_IDLE: pop = ~queue_empty;
         CORE_DONE: rsp_valid = 1'b1;
         default: begin
            pop       = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         CORE_IDLE: begin
            if (!queue_empty) begin
               num_ff      <= queue_entry.div_zero ? '0 : queue_entry.num;
               den_ff      <= queue_entry.den;
               rem_ff      <= '0;
               cnt_ff      <= STEP_W'(WORD_W - 1);
               op_ff       <= queue_entry.op;
               mode_ff     <= queue_entry.mode;
               negative_ff <= queue_entry.negative;
               status_ff   <= queue_entry.div_zero ? STATUS_DIV_ZERO : STATUS_OK;
            end
         end
         CORE_DIVIDE: begin
            rem_ff <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            num_ff <= {num_ff[WORD_W-2:0], ge};
            cnt_ff <= cnt_ff - STEP_W'(1);
         end
         CORE_ROUND: begin
            num_ff <= (op_ff == OP_REM) ? rem_ff : quo_round;
         end
         CORE_SIGN: begin
            if (negative_ff && op_ff == OP_DIV) begin
               num_ff <= ~num_ff + WORD_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_result_lo = num_ff[HALF_W-1:0];
   assign rsp_result_hi = num_ff[WORD_W-1:HALF_W];
   assign rsp_status    = status_ff;

`ifndef SYNTHESIS
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DIV_ZERO |-> num_ff == '0)
      else $error("divide by zero result not zero");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == CORE_DIVIDE && cnt_ff == '0 |=> state_ff == CORE_ROUND)
      else $error("divide loop did not end after last step");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == CORE_ROUND |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");
`endif

endmodule
